>>> hw/rtl/bkdr_pkg.sv
// Shared types and constants for the BKDR hashed direct table.
// No dependencies; imported by bkdr_hashed_direct_table.
`default_nettype none

package bkdr_pkg;

    localparam int HASH_BITS     = 64;
    localparam int HALF_BITS     = 32;
    localparam int CNT_BITS      = $clog2(HASH_BITS);
    localparam int SLOT_IDX_BITS = 10;
    localparam int PRIOR_BITS    = 32;
    localparam int ENTRIES_BITS  = 11;
    localparam int MULT_BITS     = 32;

    localparam logic [1:0] ACT_GET    = 2'd0;
    localparam logic [1:0] ACT_SET    = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    localparam logic REG_MULTIPLIER = 1'b0;
    localparam logic REG_ENTRIES    = 1'b1;

    localparam logic [MULT_BITS-1:0]    MULT_RESET    = 32'd131;
    localparam logic [ENTRIES_BITS-1:0] ENTRIES_RESET = 11'd1024;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACC,
        ST_DIV,
        ST_READ,
        ST_WRITE
    } t_state;

endpackage

`default_nettype wire

>>> hw/rtl/bkdr_hashed_direct_table.sv
// Top level of the BKDR hashed direct table: sequencer, shared multiplier,
// bit-serial remainder unit and slot memory. Depends on bkdr_pkg.
`default_nettype none

// A name byte is accepted when start is high and busy is low. Every byte
// passes through one shared 32 by 32 multiplier twice and then a 64-bit
// add. For a byte that is not the last, busy stays high through the
// ST_MUL_LO, ST_MUL_HI and ST_ACC states, and the next byte is taken only
// back in ST_IDLE. The last byte also runs a one-bit-per-cycle remainder
// unit over the 64-bit hash, then a memory read and a memory update, and
// busy stays high through all of them. The result beat appears on the
// result ports for a single cycle, marked by o_result_valid, in the last
// busy cycle of that item; the receiver cannot stall it and must take it
// then. After reset the block clears the slot memory one entry a cycle and
// holds busy high until every entry is cleared; configuration writes are
// taken throughout.
module bkdr_hashed_direct_table
    import bkdr_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_BITS  = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [2:0]               paddr,
    input  wire logic [31:0]              pwdata,
    output logic      [31:0]              prdata,
    output logic                          pready,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [1:0]               i_action,
    input  wire logic [7:0]               i_name_byte,
    input  wire logic                     i_name_last,
    input  wire logic [31:0]              i_store_value,
    output logic                          o_result_valid,
    output logic [SLOT_IDX_BITS-1:0]      o_slot_index,
    output logic [PRIOR_BITS-1:0]         o_prior_value,
    output logic                          o_found
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int DW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = (DW > ENTRIES_BITS) ? DW : ENTRIES_BITS;

    t_state r_state, n_state;

    logic [MULT_BITS-1:0]    r_mult;
    logic [ENTRIES_BITS-1:0] r_entries;
    logic [HASH_BITS-1:0]    r_hash;
    logic [HASH_BITS-1:0]    r_prod_lo;
    logic [HALF_BITS-1:0]    r_prod_hi;
    logic [HASH_BITS-1:0]    r_dividend;
    logic [DW-1:0]           r_rem;
    logic [CNT_BITS-1:0]     r_bit_cnt;
    logic [AW-1:0]           r_clr_addr;
    logic [7:0]              r_byte;
    logic                    r_last;
    logic [1:0]              r_action;
    logic [VALUE_BITS-1:0]   r_value;
    logic [VALUE_BITS-1:0]   r_rdata;
    logic [VALUE_BITS-1:0]   r_slot_mem [TABLE_DEPTH];

    logic                    w_accept;
    logic                    w_cfg_write;
    logic [HALF_BITS-1:0]    w_mul_a;
    logic [HASH_BITS-1:0]    w_product;
    logic [HASH_BITS-1:0]    w_next_hash;
    logic [CW-1:0]           w_entries_ext;
    logic [DW-1:0]           w_divisor;
    logic [DW:0]             w_trial;
    logic [DW-1:0]           w_next_rem;
    logic [AW-1:0]           w_slot;
    logic                    w_mem_we;
    logic [AW-1:0]           w_mem_addr;
    logic [VALUE_BITS-1:0]   w_mem_wdata;

    // Configuration port.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            REG_MULTIPLIER: prdata = r_mult;
            REG_ENTRIES:    prdata = 32'(r_entries);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult    <= MULT_RESET;
            r_entries <= ENTRIES_RESET;
        end else if (w_cfg_write) begin
            unique case (paddr[2])
                REG_MULTIPLIER: r_mult    <= pwdata;
                REG_ENTRIES:    r_entries <= pwdata[ENTRIES_BITS-1:0];
                default:        r_mult    <= r_mult;
            endcase
        end
    end

    // The divisor is held in the range 1 to TABLE_DEPTH.
    assign w_entries_ext = CW'(r_entries);
    always_comb begin
        if (w_entries_ext == '0) begin
            w_divisor = DW'(1);
        end else if (w_entries_ext > CW'(TABLE_DEPTH)) begin
            w_divisor = DW'(TABLE_DEPTH);
        end else begin
            w_divisor = DW'(w_entries_ext);
        end
    end

    // Shared arithmetic: one multiplier, the accumulate add and the
    // restoring remainder step.
    assign w_mul_a     = (r_state == ST_MUL_HI) ? r_hash[HASH_BITS-1:HALF_BITS]
                                                : r_hash[HALF_BITS-1:0];
    assign w_product   = HASH_BITS'(w_mul_a) * HASH_BITS'(r_mult);
    assign w_next_hash = r_prod_lo + {r_prod_hi, {HALF_BITS{1'b0}}}
                       + HASH_BITS'(r_byte);
    assign w_trial     = {r_rem, r_dividend[HASH_BITS-1]};
    assign w_next_rem  = (w_trial >= {1'b0, w_divisor}) ? DW'(w_trial - {1'b0, w_divisor})
                                                         : DW'(w_trial);
    assign w_slot      = r_rem[AW-1:0];

    // Sequencer: next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (r_clr_addr == AW'(TABLE_DEPTH - 1)) n_state = ST_IDLE;
            ST_IDLE:   if (start) n_state = ST_MUL_LO;
            ST_MUL_LO: n_state = ST_MUL_HI;
            ST_MUL_HI: n_state = ST_ACC;
            ST_ACC:    n_state = r_last ? ST_DIV : ST_IDLE;
            ST_DIV:    if (r_bit_cnt == CNT_BITS'(HASH_BITS - 1)) n_state = ST_READ;
            ST_READ:   n_state = ST_WRITE;
            ST_WRITE:  n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Sequencer: outputs and memory write control.
    always_comb begin
        busy           = 1'b1;
        o_result_valid = 1'b0;
        w_mem_we       = 1'b0;
        w_mem_addr     = w_slot;
        w_mem_wdata    = '0;
        unique case (r_state)
            ST_CLEAR: begin
                w_mem_we   = 1'b1;
                w_mem_addr = r_clr_addr;
            end
            ST_IDLE: begin
                busy = 1'b0;
            end
            ST_WRITE: begin
                o_result_valid = 1'b1;
                case (r_action)
                    ACT_SET: begin
                        w_mem_we    = 1'b1;
                        w_mem_wdata = r_value;
                    end
                    ACT_REMOVE: begin
                        w_mem_we = 1'b1;
                    end
                    default: begin
                        w_mem_we = 1'b0;
                    end
                endcase
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_hash     <= '0;
            r_bit_cnt  <= '0;
            r_rem      <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                end
                ST_ACC: begin
                    if (r_last) begin
                        r_hash     <= '0;
                        r_dividend <= w_next_hash;
                        r_rem      <= '0;
                        r_bit_cnt  <= '0;
                    end else begin
                        r_hash <= w_next_hash;
                    end
                end
                ST_DIV: begin
                    r_rem      <= w_next_rem;
                    r_dividend <= {r_dividend[HASH_BITS-2:0], 1'b0};
                    r_bit_cnt  <= r_bit_cnt + CNT_BITS'(1);
                end
                default: begin
                    r_bit_cnt <= r_bit_cnt;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte   <= i_name_byte;
            r_last   <= i_name_last;
            r_action <= i_action;
            r_value  <= VALUE_BITS'(i_store_value);
        end
        if (r_state == ST_MUL_LO) begin
            r_prod_lo <= w_product;
        end
        if (r_state == ST_MUL_HI) begin
            r_prod_hi <= w_product[HALF_BITS-1:0];
        end
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_slot_mem[w_mem_addr] <= w_mem_wdata;
        end
        if (r_state == ST_READ) begin
            r_rdata <= r_slot_mem[w_slot];
        end
    end

    assign o_slot_index  = SLOT_IDX_BITS'(w_slot);
    assign o_prior_value = PRIOR_BITS'(r_rdata);
    assign o_found       = (r_rdata != '0);

`ifndef NO_ASSERTIONS
    a_accept_starts_multiply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_MUL_LO))
        else $error("accepted beat did not start the multiply sequence");

    a_result_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state == ST_READ))
        else $error("result beat without a preceding memory read");

    a_remainder_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV || r_state == ST_READ) |-> (r_rem < w_divisor))
        else $error("remainder not below divisor");

    a_hash_cleared_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACC && r_last) |=> (r_hash == '0))
        else $error("hash not cleared after the last byte");

    a_no_accept_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> busy)
        else $error("block ready during the clearing pass");
`endif

endmodule

`default_nettype wire

>>> tb/bkdr_hashed_direct_table_tb.sv
// Self-checking testbench for the BKDR hashed direct table: drives name beats and APB
// register writes, predicts every lookup result and checks each result beat.
// Depends on bkdr_pkg and bkdr_hashed_direct_table.
`timescale 1ns / 100ps

module bkdr_hashed_direct_table_tb;
    import bkdr_pkg::*;

    localparam int          DEPTH       = 1024;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          PHASE_BEATS = 100;
    localparam logic [1:0]  ACT_SPARE   = 2'd3;

    typedef struct {
        logic [1:0]  action;
        logic [7:0]  name_byte;
        logic        name_last;
        logic [31:0] store_value;
        bit          drain_first;
    } t_name_beat;

    typedef struct {
        logic [SLOT_IDX_BITS-1:0] slot;
        logic [PRIOR_BITS-1:0]    prior;
        logic                     found;
    } t_slot_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_action = '0;
    logic [7:0]  i_name_byte = '0;
    logic        i_name_last = 1'b0;
    logic [31:0] i_store_value = '0;
    logic                     o_result_valid;
    logic [SLOT_IDX_BITS-1:0] o_slot_index;
    logic [PRIOR_BITS-1:0]    o_prior_value;
    logic                     o_found;

    t_name_beat   name_beats_q[$];
    t_slot_result slot_results_q[$];
    t_name_beat   beat_on_port;

    logic [MULT_BITS-1:0]    mult_copy = MULT_RESET;
    logic [ENTRIES_BITS-1:0] entries_copy = ENTRIES_RESET;
    logic [HASH_BITS-1:0]    hash_copy = '0;
    logic [31:0]             slot_copy [DEPTH];

    logic [7:0] name_pool [16][6];
    int         name_len [16];
    int         gap_max = 12;
    int         gap_left = 0;
    int         queued_beats = 0;
    int         mismatches = 0;
    int         cycle_count = 0;

    bkdr_hashed_direct_table DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_name_byte    (i_name_byte),
        .i_name_last    (i_name_last),
        .i_store_value  (i_store_value),
        .o_result_valid (o_result_valid),
        .o_slot_index   (o_slot_index),
        .o_prior_value  (o_prior_value),
        .o_found        (o_found)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
        begin
            $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
            mismatches++;
        end
    endtask

    // Advances the hash copy by one byte and, on the last byte, works out the slot lookup and applies a set or remove.
    task predict_lookup(input t_name_beat b);
        logic [ENTRIES_BITS-1:0] div;
        logic [HASH_BITS-1:0]    slot;
        t_slot_result            res;
        begin
            hash_copy = {56'd0, b.name_byte} + hash_copy * {32'd0, mult_copy};
            if (b.name_last) begin
                div = entries_copy;
                if (div < ENTRIES_BITS'(1))
                    div = ENTRIES_BITS'(1);
                if (div > ENTRIES_BITS'(DEPTH))
                    div = ENTRIES_BITS'(DEPTH);
                slot = hash_copy % {53'd0, div};
                hash_copy = '0;
                res.slot  = slot[SLOT_IDX_BITS-1:0];
                res.prior = slot_copy[slot[SLOT_IDX_BITS-1:0]];
                res.found = (res.prior != 0);
                if (b.action == ACT_SET)
                    slot_copy[slot[SLOT_IDX_BITS-1:0]] = b.store_value;
                else if (b.action == ACT_REMOVE)
                    slot_copy[slot[SLOT_IDX_BITS-1:0]] = '0;
                slot_results_q.push_back(res);
            end
        end
    endtask

    task present_beat;
        begin
            beat_on_port = name_beats_q.pop_front();
            i_action      <= beat_on_port.action;
            i_name_byte   <= beat_on_port.name_byte;
            i_name_last   <= beat_on_port.name_last;
            i_store_value <= beat_on_port.store_value;
            start         <= 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                predict_lookup(beat_on_port);
                gap_left = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
                if (gap_left == 0 && name_beats_q.size() > 0 && !name_beats_q[0].drain_first)
                    present_beat();
                else
                    start <= 1'b0;
            end else if (!start) begin
                if (gap_left > 0)
                    gap_left--;
                else if (name_beats_q.size() > 0 &&
                         (!name_beats_q[0].drain_first || slot_results_q.size() == 0))
                    present_beat();
            end
        end
    end

    always @(posedge i_clk) begin
        t_slot_result want;
        if (i_rst_n && o_result_valid) begin
            if (slot_results_q.size() == 0) begin
                report_mismatch("unexpected result beat, slot", 32'(o_slot_index), '0);
            end else begin
                want = slot_results_q.pop_front();
                if (o_slot_index !== want.slot)
                    report_mismatch("slot_index", 32'(o_slot_index), 32'(want.slot));
                if (o_prior_value !== want.prior)
                    report_mismatch("prior_value", o_prior_value, want.prior);
                if (o_found !== want.found)
                    report_mismatch("found", 32'(o_found), 32'(want.found));
            end
        end
    end

    task apb_write(input logic reg_idx, input logic [31:0] data);
        begin
            @(posedge i_clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {reg_idx, 2'b00};
            pwdata  <= data;
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            if (reg_idx == REG_MULTIPLIER)
                mult_copy = data;
            else
                entries_copy = data[ENTRIES_BITS-1:0];
        end
    endtask

    task wait_drained;
        begin
            do @(negedge i_clk);
            while (name_beats_q.size() != 0 || start || slot_results_q.size() != 0 || busy);
            repeat (8) @(negedge i_clk);
        end
    endtask

    task queue_beat(input logic [1:0] act, input logic [7:0] b, input logic last,
                    input logic [31:0] val, input bit drain);
        t_name_beat nb;
        begin
            nb.action      = act;
            nb.name_byte   = b;
            nb.name_last   = last;
            nb.store_value = val;
            nb.drain_first = drain;
            name_beats_q.push_back(nb);
            queued_beats++;
        end
    endtask

    task queue_name(input int idx, input logic [1:0] act, input logic [31:0] val,
                    input bit drain);
        begin
            for (int i = 0; i < name_len[idx] - 1; i++)
                queue_beat(2'($urandom_range(0, 3)), name_pool[idx][i], 1'b0, $urandom,
                           (i == 0) && drain);
            queue_beat(act, name_pool[idx][name_len[idx]-1], 1'b1, val,
                       (name_len[idx] == 1) && drain);
        end
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 19);
        if (r < 2)
            return '0;
        if (r == 2)
            return '1;
        return $urandom;
    endfunction

    task fresh_name(input int idx);
        begin
            name_len[idx] = $urandom_range(1, 5);
            for (int i = 0; i < 6; i++)
                name_pool[idx][i] = pick_byte();
        end
    endtask

    task queue_random_phase;
        int          r;
        int          idx;
        logic [1:0]  act;
        begin
            queued_beats = 0;
            while (queued_beats < PHASE_BEATS) begin
                r = $urandom_range(0, 99);
                if (r < 12) begin
                    queue_beat(2'($urandom_range(0, 3)), pick_byte(),
                               1'($urandom_range(0, 1)), pick_value(), 1'b0);
                end else begin
                    idx = $urandom_range(1, 15);
                    if ($urandom_range(0, 3) == 0)
                        fresh_name(idx);
                    r = $urandom_range(0, 9);
                    act = (r < 4) ? ACT_SET : (r < 7) ? ACT_GET :
                          (r < 9) ? ACT_REMOVE : ACT_SPARE;
                    queue_name(idx, act, pick_value(), $urandom_range(0, 39) == 0);
                end
            end
        end
    endtask

    logic [31:0] phase_mult [7];
    logic [31:0] phase_entries [7];

    initial begin
        for (int i = 0; i < DEPTH; i++)
            slot_copy[i] = '0;
        for (int i = 0; i < 16; i++)
            fresh_name(i);
        name_len[0] = 3;
        name_pool[0][0] = 8'h00;
        name_pool[0][1] = 8'hFF;
        name_pool[0][2] = 8'h41;
        name_len[1] = 1;
        name_pool[1][0] = 8'hFF;
        name_len[2] = 1;
        name_pool[2][0] = 8'h00;

        phase_mult[0] = 32'd1;          phase_entries[0] = 32'd1;
        phase_mult[1] = 32'hFFFF_FFFF;  phase_entries[1] = 32'd1024;
        phase_mult[2] = 32'd0;          phase_entries[2] = 32'd2047;
        phase_mult[3] = 32'd31;         phase_entries[3] = 32'd0;
        phase_mult[4] = $urandom_range(1, 32'hFFFF_FFFF);
        phase_entries[4] = $urandom_range(1, 1024);
        phase_mult[5] = 32'd131;        phase_entries[5] = 32'd1000;
        phase_mult[6] = $urandom;       phase_entries[6] = 32'd2;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        apb_write(REG_MULTIPLIER, 32'd131);
        apb_write(REG_ENTRIES, 32'd1024);
        queue_name(2, ACT_GET, '0, 1'b0);
        queue_name(1, ACT_SET, 32'hFFFF_FFFF, 1'b0);
        queue_name(1, ACT_GET, pick_value(), 1'b0);
        queue_name(1, ACT_REMOVE, pick_value(), 1'b0);
        queue_name(1, ACT_GET, '0, 1'b0);
        queue_name(0, ACT_SET, 32'hA5A5_5A5A, 1'b0);
        queue_name(0, ACT_SPARE, 32'h1234_5678, 1'b0);
        queue_name(0, ACT_GET, '0, 1'b0);
        queue_name(0, ACT_SET, '0, 1'b1);
        queue_name(0, ACT_GET, '1, 1'b0);
        queue_name(0, ACT_REMOVE, '1, 1'b0);
        queue_name(2, ACT_SET, 32'h0000_0001, 1'b0);
        queue_name(2, ACT_REMOVE, '0, 1'b0);
        wait_drained();

        for (int p = 0; p < 7; p++) begin
            apb_write(REG_MULTIPLIER, phase_mult[p]);
            apb_write(REG_ENTRIES, phase_entries[p]);
            gap_max = (p == 3) ? 0 : 12;
            @(negedge i_clk);
            queue_random_phase();
            wait_drained();
        end

        repeat (80) @(posedge i_clk);
        if (slot_results_q.size() != 0)
            report_mismatch("result beats still awaited", 32'(slot_results_q.size()), '0);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
